// File: design/canonical_huffman_byte_encoder_assert.svh
// assertion macros for the canonical huffman byte encoder
`ifndef CANONICAL_HUFFMAN_BYTE_ENCODER_ASSERT_SVH
`define CANONICAL_HUFFMAN_BYTE_ENCODER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CHBE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CHBE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/chbe_pkg.sv
// shared types and constants for the canonical huffman byte encoder
package chbe_pkg;

  localparam int SymW     = 8;
  localparam int LenW     = 4;
  localparam int CodeW    = 15;
  localparam int FirstW   = 16;
  localparam int CountW   = 9;
  localparam int NumLens  = 16;
  localparam int PendW    = 7;
  localparam int PcntW    = 3;
  localparam int AccW     = 22;
  localparam int CntW     = 5;
  localparam int ByteBits = 8;
  localparam logic [ByteBits-1:0] ByteMask = 8'hFF;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_BUILD  = 2'd1,
    KIND_ENCODE = 2'd2,
    KIND_FLUSH  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [SymW-1:0]   symbol;
    logic [LenW-1:0]   code_length;
  } enc_item_t;

  typedef struct packed {
    logic [ByteBits-1:0] out_byte;
    logic                byte_valid;
    logic                stream_end;
    logic [PcntW-1:0]    pad_bits;
    logic                no_code_error;
    logic                last_of_run;
  } enc_result_t;

  typedef struct packed {
    logic form;
    logic emit;
    logic flush;
  } pack_ctrl_t;

endpackage

// File: design/chbe_len_store.sv
// code length memory with per-entry valid bits and registered read
module chbe_len_store #(
  parameter int SYMBOL_COUNT = 256,
  parameter int ADDR_W       = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [ADDR_W-1:0]       wr_addr_i,
  input  logic [chbe_pkg::LenW-1:0] wr_len_i,
  input  logic [ADDR_W-1:0]       rd_addr_i,
  output logic [chbe_pkg::LenW-1:0] rd_len_o
);
  import chbe_pkg::*;

  logic [LenW-1:0] mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld_q;
  logic [LenW-1:0] rd_len_q;
  logic            rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_len_i;
    end
    rd_len_q <= mem[rd_addr_i];
  end

  // entries never loaded read as zero length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_len_o = rd_vld_q ? rd_len_q : '0;

endmodule

// File: design/chbe_code_store.sv
// canonical code memory, reads zero until the first build has written it
module chbe_code_store #(
  parameter int SYMBOL_COUNT = 256,
  parameter int ADDR_W       = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [ADDR_W-1:0]          wr_addr_i,
  input  logic [chbe_pkg::CodeW-1:0] wr_code_i,
  input  logic [ADDR_W-1:0]          rd_addr_i,
  output logic [chbe_pkg::CodeW-1:0] rd_code_o
);
  import chbe_pkg::*;

  logic [CodeW-1:0] mem [SYMBOL_COUNT];
  logic             built_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_code_i;
    end
    rd_code_o <= built_q ? mem[rd_addr_i] : '0;
  end

  // a build writes every entry, so one flag covers the whole table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      built_q <= 1'b0;
    end else if (wr_en_i) begin
      built_q <= 1'b1;
    end
  end

endmodule

// File: design/chbe_packer.sv
// bit packer: shared shift unit, pending bit buffer and result register
module chbe_packer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  chbe_pkg::pack_ctrl_t       ctrl_i,
  input  logic [chbe_pkg::LenW-1:0]  len_i,
  input  logic [chbe_pkg::CodeW-1:0] code_i,
  input  logic                       sym_bad_i,
  output logic                       more_o,
  output logic                       strobe_o,
  output chbe_pkg::enc_result_t      result_o
);
  import chbe_pkg::*;

  logic [PendW-1:0] pend_q, pend_d;
  logic [PcntW-1:0] pcnt_q, pcnt_d;
  logic [AccW-1:0]  acc_q, acc_w;
  logic [CntW-1:0]  cnt_q, cnt_w, cnt_n, cnt_keep;
  logic [FirstW-1:0] cmask;
  logic [ByteBits-1:0] pmask;
  logic             err, has_byte, work;
  logic [PcntW-1:0] pad;
  logic             strobe_d;
  enc_result_t      res_d;

  always_comb begin
    cmask = (FirstW'(1) << len_i) - FirstW'(1);
    if (ctrl_i.emit) begin
      acc_w = acc_q;
      cnt_w = cnt_q;
    end else begin
      acc_w = (AccW'(pend_q) << len_i) | AccW'(code_i & cmask[CodeW-1:0]);
      cnt_w = CntW'(pcnt_q) + CntW'(len_i);
    end
    err      = ctrl_i.form && (sym_bad_i || len_i == '0);
    work     = (ctrl_i.form && !err) || ctrl_i.emit;
    has_byte = cnt_w >= CntW'(ByteBits);
    cnt_n    = cnt_w - CntW'(ByteBits);
    more_o   = work && has_byte && (cnt_n >= CntW'(ByteBits));
    cnt_keep = has_byte ? cnt_n : cnt_w;
    pmask    = (ByteBits'(1) << cnt_keep[PcntW-1:0]) - ByteBits'(1);
    pad      = PcntW'(CntW'(ByteBits) - CntW'(pcnt_q));

    pend_d   = pend_q;
    pcnt_d   = pcnt_q;
    strobe_d = 1'b0;
    res_d    = '0;

    if (ctrl_i.flush) begin
      strobe_d         = 1'b1;
      res_d.stream_end = 1'b1;
      res_d.last_of_run = 1'b1;
      if (pcnt_q != '0) begin
        res_d.out_byte   = ByteBits'(ByteBits'(pend_q) << pad) & ByteMask;
        res_d.byte_valid = 1'b1;
        res_d.pad_bits   = pad;
      end
      pend_d = '0;
      pcnt_d = '0;
    end else if (err) begin
      strobe_d            = 1'b1;
      res_d.no_code_error = 1'b1;
      res_d.last_of_run   = 1'b1;
    end else if (work) begin
      if (has_byte) begin
        strobe_d          = 1'b1;
        res_d.out_byte    = ByteBits'(acc_w >> cnt_n);
        res_d.byte_valid  = 1'b1;
        res_d.last_of_run = cnt_n < CntW'(ByteBits);
      end
      if (!more_o) begin
        pend_d = PendW'(acc_w) & pmask[PendW-1:0];
        pcnt_d = cnt_keep[PcntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      pcnt_q   <= '0;
      strobe_o <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      pcnt_q   <= pcnt_d;
      strobe_o <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (more_o) begin
      acc_q <= acc_w;
      cnt_q <= cnt_n;
    end
    if (strobe_d) begin
      result_o <= res_d;
    end
  end

endmodule

// File: design/canonical_huffman_byte_encoder.sv
// top level of the canonical huffman byte encoder
// Command-style block: a transaction is taken when start is high and busy is
// low, and every result is shown on result_o for exactly one cycle with
// result_strobe_o high; the receiver cannot stall, so it must take each result
// in that cycle. A load transaction writes the symbol's code length (lengths
// above MAX_CODE_BITS are clamped, symbols beyond SYMBOL_COUNT ignored) and
// leaves busy low, so the next transaction may follow in the next cycle. A
// flush transaction also leaves busy low; its single result (padded last byte
// and pad count, or an empty marker) appears in the following cycle. An encode
// transaction holds busy while the packer works on the length and code read at
// the accepting edge, so a new symbol cannot be taken until that work is done; a
// symbol that completes two bytes holds busy through the emit state as well, and
// the two bytes come out on consecutive cycles. The first result of an encode
// appears in the cycle after its first busy cycle. A build transaction walks the
// length memory twice through its single read port (once to count lengths, once
// to hand out codes) and steps the first-code recurrence through one shared
// adder in between, holding busy for the whole build. Loads after a build take
// effect for encoding with the codes of that build until the next build.
module canonical_huffman_byte_encoder #(
  parameter int SYMBOL_COUNT  = 256,
  parameter int MAX_CODE_BITS = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  chbe_pkg::enc_item_t   item_i,
  output logic                  busy,
  output logic                  result_strobe_o,
  output chbe_pkg::enc_result_t result_o
);
  import chbe_pkg::*;

  localparam int AddrW   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int SymCntW = AddrW + 1;
  localparam int TopLen  = (MAX_CODE_BITS > 15) ? 15 : MAX_CODE_BITS;
  localparam logic [SymCntW-1:0] SymEnd  = SymCntW'(SYMBOL_COUNT);
  localparam logic [LenW-1:0]    TopLenV = LenW'(TopLen);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CNT   = 3'd1;  // count symbols per length
  localparam logic [2:0] S_FIRST = 3'd2;  // first code per length
  localparam logic [2:0] S_ASG   = 3'd3;  // hand out codes
  localparam logic [2:0] S_ENC   = 3'd4;  // memories read, pack symbol
  localparam logic [2:0] S_EMIT  = 3'd5;  // second completed byte

  logic [2:0]         state_q, state_d;
  logic               accept, in_range, issue;
  logic [AddrW-1:0]   item_addr, len_rd_addr, pa_q;
  logic [SymCntW-1:0] sym_q;
  logic               pv_q, pv_d;
  logic [LenW-1:0]    bit_q;
  logic [FirstW-1:0]  code_q, first_sum, code_next;
  logic [CountW-1:0]  counts_q [NumLens];
  logic [FirstW-1:0]  next_q [NumLens];
  logic [LenW-1:0]    len_rd, load_len;
  logic [CodeW-1:0]   code_rd, code_wr_data;
  logic [FirstW-1:0]  asg_mask;
  logic               code_wr_en, len_wr_en;
  logic               sym_bad_q;
  logic               more;
  pack_ctrl_t         pctrl;

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign in_range  = (int'(item_i.symbol) < SYMBOL_COUNT);
  assign item_addr = item_i.symbol[AddrW-1:0];
  assign issue     = (sym_q != SymEnd);

  // clamp loaded lengths to the longest code the table supports
  assign load_len  = (item_i.code_length > TopLenV) ? TopLenV : item_i.code_length;
  assign len_wr_en = accept && (item_i.kind == KIND_LOAD) && in_range;

  // the length port serves the encoder when idle and the build walk otherwise
  assign len_rd_addr = (state_q == S_IDLE) ? item_addr : sym_q[AddrW-1:0];

  // shared adder of the first-code recurrence
  assign first_sum = code_q + FirstW'(counts_q[bit_q - LenW'(1)]);
  assign code_next = {first_sum[FirstW-2:0], 1'b0};

  // code for the symbol whose length is in flight, cut to its length
  assign asg_mask     = (FirstW'(1) << len_rd) - FirstW'(1);
  assign code_wr_data = next_q[len_rd][CodeW-1:0] & asg_mask[CodeW-1:0];
  assign code_wr_en   = (state_q == S_ASG) && pv_q;

  assign pctrl.form  = (state_q == S_ENC);
  assign pctrl.emit  = (state_q == S_EMIT);
  assign pctrl.flush = accept && (item_i.kind == KIND_FLUSH);

  always_comb begin
    state_d = state_q;
    pv_d    = ((state_q == S_CNT) || (state_q == S_ASG)) && issue;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (item_i.kind)
            KIND_BUILD:  state_d = S_CNT;
            KIND_ENCODE: state_d = S_ENC;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_CNT: begin
        if (!issue && !pv_q) state_d = S_FIRST;
      end
      S_FIRST: begin
        if (bit_q == TopLenV) state_d = S_ASG;
      end
      S_ASG: begin
        if (!issue && !pv_q) state_d = S_IDLE;
      end
      S_ENC: begin
        state_d = more ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        state_d = more ? S_EMIT : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= pv_d;
    end
  end

  // build datapath: walk counter, length counts and running next codes
  always_ff @(posedge clk_i) begin
    pa_q <= sym_q[AddrW-1:0];
    if (accept) begin
      sym_bad_q <= !in_range;
    end
    case (state_q)
      S_IDLE: begin
        if (accept && (item_i.kind == KIND_BUILD)) begin
          sym_q  <= '0;
          bit_q  <= LenW'(1);
          code_q <= '0;
          for (int i = 0; i < NumLens; i++) begin
            counts_q[i] <= '0;
          end
        end
      end
      S_CNT: begin
        if (issue) sym_q <= sym_q + SymCntW'(1);
        if (pv_q && (len_rd != '0)) begin
          counts_q[len_rd] <= counts_q[len_rd] + CountW'(1);
        end
      end
      S_FIRST: begin
        next_q[bit_q] <= code_next;
        code_q        <= code_next;
        bit_q         <= bit_q + LenW'(1);
        sym_q         <= '0;
      end
      S_ASG: begin
        if (issue) sym_q <= sym_q + SymCntW'(1);
        if (pv_q && (len_rd != '0)) begin
          next_q[len_rd] <= next_q[len_rd] + FirstW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  chbe_len_store #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .ADDR_W       (AddrW)
  ) u_len (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (len_wr_en),
    .wr_addr_i (item_addr),
    .wr_len_i  (load_len),
    .rd_addr_i (len_rd_addr),
    .rd_len_o  (len_rd)
  );

  chbe_code_store #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .ADDR_W       (AddrW)
  ) u_code (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (code_wr_en),
    .wr_addr_i (pa_q),
    .wr_code_i (code_wr_data),
    .rd_addr_i (item_addr),
    .rd_code_o (code_rd)
  );

  chbe_packer u_pack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (pctrl),
    .len_i     (len_rd),
    .code_i    (code_rd),
    .sym_bad_i (sym_bad_q),
    .more_o    (more),
    .strobe_o  (result_strobe_o),
    .result_o  (result_o)
  );

endmodule

// File: design/chbe_checker.sv
// port-level checker for the canonical huffman byte encoder and its bind
`include "canonical_huffman_byte_encoder_assert.svh"

module chbe_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input chbe_pkg::enc_item_t   item_i,
  input logic                  busy,
  input logic                  result_strobe_o,
  input chbe_pkg::enc_result_t result_o
);
  import chbe_pkg::*;

  `CHBE_ASSERT_IMP(a_end_is_last, clk_i, rst_ni, result_strobe_o && result_o.stream_end, result_o.last_of_run && !result_o.no_code_error, "flush result not last of run")
  `CHBE_ASSERT_IMP(a_err_clean, clk_i, rst_ni, result_strobe_o && result_o.no_code_error, !result_o.byte_valid && result_o.last_of_run && (result_o.out_byte == 8'h00), "error result carries data")
  `CHBE_ASSERT_NXT(a_run_continues, clk_i, rst_ni, result_strobe_o && !result_o.last_of_run, result_strobe_o, "byte run broken")
  `CHBE_ASSERT_NXT(a_enc_busy, clk_i, rst_ni, start && !busy && (item_i.kind == KIND_ENCODE), busy, "encode not busy after accept")
  `CHBE_ASSERT_IMP(a_empty_byte, clk_i, rst_ni, result_strobe_o && !result_o.byte_valid, (result_o.out_byte == 8'h00) && (result_o.pad_bits == 3'd0), "empty result not zero")

endmodule

bind canonical_huffman_byte_encoder chbe_checker u_chbe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .item_i          (item_i),
  .busy            (busy),
  .result_strobe_o (result_strobe_o),
  .result_o        (result_o)
);
